@@ hdl/hts_pkg.sv @@
package hts_pkg;

  // Byte stages in the lookahead chain; must cover the longest tag.
  localparam int WINDOW_DEPTH = 13;
  localparam int MAX_TAG_LEN  = 13;
  localparam int TAG_COUNT    = 11;
  localparam int CNT_W        = $clog2(MAX_TAG_LEN);
  localparam int TAG_STR_W    = 8 * MAX_TAG_LEN;

  localparam logic [7:0] CHAR_LT = 8'h3C;
  localparam logic [7:0] CHAR_GT = 8'h3E;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Removable tags in priority order, first match wins.
  localparam logic [TAG_STR_W-1:0] TAG_STR [TAG_COUNT] = '{
    "<br />", "<br>", "<p>", "</p>", "<cite>", "</cite>",
    "<a ", "</a>", "<img ", "<blockquote>", "</blockquote>"
  };
  localparam int   TAG_LEN  [TAG_COUNT] = '{6, 4, 3, 4, 6, 7, 3, 4, 5, 12, 13};
  localparam logic TAG_SKIP [TAG_COUNT] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                            1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

  // One stage of the byte chain.
  typedef struct packed {
    logic       valid;
    logic       fin;
    logic [7:0] data;
  } cell_t;

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_t;

  // Results that the head step produces, in order.
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } head_res_t;

  // Character j of tag t; string literals sit right-justified.
  function automatic logic [7:0] tag_byte(input int t, input int j);
    logic [TAG_STR_W-1:0] s;
    s = TAG_STR[t] >> (8 * (TAG_LEN[t] - 1 - j));
    return s[7:0];
  endfunction

endpackage

@@ hdl/html_tag_stripper.sv @@
// One byte per cycle within a string while the output is not stalled; a final
// byte closes the input until it drains the chain, and an end with two results
// parks the second. A byte is decided after crossing the 13-stage chain and
// leaves once the next kept byte or the end of its string is decided.
// Reset (synchronous, active high) empties the chain and clears all flags.
module html_tag_stripper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);
  import hts_pkg::*;

  cell_t     chain_d [WINDOW_DEPTH];
  cell_t     chain_q [WINDOW_DEPTH];
  cell_t     head_win [MAX_TAG_LEN];
  head_res_t hres;
  res_t      res_q;
  res_t      owed_q;
  logic      owed_valid;
  logic      flushing;
  logic      load_free;
  logic      advance_ok;
  logic      accept;
  logic      advance;
  logic      head_fin;
  logic [WINDOW_DEPTH-1:0] fin_mark;

  // Build the byte chain; new requests enter at the tail.
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_chain
    if (k == WINDOW_DEPTH - 1) begin : g_tail
      assign chain_d[k] = '{valid: accept, fin: is_final, data: in_byte};
    end else begin : g_mid
      assign chain_d[k] = chain_q[k + 1];
    end
    assign fin_mark[k] = chain_q[k].valid & chain_q[k].fin;
    hts_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (advance),
      .d     (chain_d[k]),
      .q     (chain_q[k])
    );
  end

  for (genvar j = 0; j < MAX_TAG_LEN; j++) begin : g_win
    assign head_win[j] = chain_q[j];
  end

  hts_head u_head (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .win  (head_win),
    .hres (hres)
  );

  // Advance when the output can take what the head produces.
  always_comb begin
    load_free  = !res_valid || res_ready;
    advance_ok = !owed_valid && (load_free || (hres.count == 2'd0));
    in_ready   = advance_ok && !flushing;
    accept     = in_valid && in_ready;
    advance    = accept || (flushing && advance_ok);
    head_fin   = chain_q[0].valid && chain_q[0].fin;
  end

  // Hold off new requests while a final byte drains the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      flushing <= 1'b0;
    end else if (accept && is_final) begin
      flushing <= 1'b1;
    end else if (advance && head_fin) begin
      flushing <= 1'b0;
    end
  end

  // Load the output register; park a second end result until the register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      owed_valid <= 1'b0;
    end else if (owed_valid && load_free) begin
      res_valid  <= 1'b1;
      res_q      <= owed_q;
      owed_valid <= 1'b0;
    end else if (advance && (hres.count != 2'd0)) begin
      res_valid <= 1'b1;
      res_q     <= hres.res0;
      if (hres.count == 2'd2) begin
        owed_valid <= 1'b1;
        owed_q     <= hres.res1;
      end
    end else if (load_free) begin
      res_valid <= 1'b0;
    end
  end

  assign out_byte  = res_q.data;
  assign out_valid = res_q.valid;
  assign out_last  = res_q.last;

  // A parked result always sits behind a full output register.
  a_owed_behind_output: assert property (@(posedge clk) disable iff (rst)
    owed_valid |-> res_valid)
    else $error("parked result without a result in the output register");

  // The chain never holds the ends of two strings.
  a_one_fin: assert property (@(posedge clk) disable iff (rst)
    $countones(fin_mark) <= 1)
    else $error("more than one final byte in the chain");

  // A final byte in the chain keeps the input closed.
  a_fin_flushing: assert property (@(posedge clk) disable iff (rst)
    (fin_mark != '0) |-> flushing)
    else $error("final byte in the chain while not draining");

  // The drain ends exactly when the final byte leaves the head.
  a_flush_end: assert property (@(posedge clk) disable iff (rst)
    (flushing && advance && head_fin) |=> !flushing && (fin_mark == '0))
    else $error("drain did not end with the final byte");

endmodule

@@ hdl/hts_cell.sv @@
module hts_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  hts_pkg::cell_t d,
  output hts_pkg::cell_t q
);
  import hts_pkg::*;

  // Take the neighbor's byte on every chain advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

@@ hdl/hts_head.sv @@
module hts_head (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  hts_pkg::cell_t    win [hts_pkg::MAX_TAG_LEN],
  output hts_pkg::head_res_t hres
);
  import hts_pkg::*;

  logic [CNT_W-1:0] drop_cnt;
  logic             skip;
  logic             w_reached;
  logic             pend_valid;
  logic             pend_in_w;
  logic [7:0]       pend_data;

  logic [MAX_TAG_LEN-1:0] avail_all;
  logic [MAX_TAG_LEN-1:0] avail_pre;
  logic [TAG_COUNT-1:0]   match_all;
  logic [TAG_COUNT-1:0]   ruled_pre;
  logic [TAG_COUNT-1:0]   full_pre;
  logic                   hit;
  logic [CNT_W-1:0]       hit_len;
  logic                   hit_skip;
  logic                   wait_pre;
  logic                   drop_tail;
  logic                   is_crlf;
  logic                   kept;
  logic                   w_set;
  res_t                   cand_r;
  res_t                   pend_r;
  res_t                   marker_r;

  // Mark the bytes of this string that the window can see.
  always_comb begin
    logic fin_seen;
    for (int j = 0; j < MAX_TAG_LEN; j++) begin
      fin_seen = 1'b0;
      for (int k = 0; k < j; k++) begin
        fin_seen = fin_seen | (win[k].valid & win[k].fin);
      end
      avail_all[j] = win[j].valid & ~fin_seen;
      avail_pre[j] = win[j].valid & ~fin_seen & ~win[j].fin;
    end
  end

  // Compare every tag against the window in parallel.
  always_comb begin
    logic eq;
    for (int t = 0; t < TAG_COUNT; t++) begin
      match_all[t] = 1'b1;
      ruled_pre[t] = 1'b0;
      full_pre[t]  = 1'b1;
      for (int j = 0; j < MAX_TAG_LEN; j++) begin
        if (j < TAG_LEN[t]) begin
          eq = (win[j].data == tag_byte(t, j));
          match_all[t] = match_all[t] & avail_all[j] & eq;
          ruled_pre[t] = ruled_pre[t] | (avail_pre[j] & ~eq);
          full_pre[t]  = full_pre[t] & avail_pre[j] & eq;
        end
      end
    end
  end

  // Pick the first full match, and check whether the first open tag would
  // still wait without the final byte.
  always_comb begin
    hit      = 1'b0;
    hit_len  = '0;
    hit_skip = 1'b0;
    wait_pre = 1'b0;
    for (int t = TAG_COUNT - 1; t >= 0; t--) begin
      if (match_all[t]) begin
        hit      = 1'b1;
        hit_len  = CNT_W'(TAG_LEN[t] - 1);
        hit_skip = TAG_SKIP[t];
      end
      if (!ruled_pre[t]) begin
        wait_pre = ~full_pre[t];
      end
    end
  end

  // Classify the head byte.
  always_comb begin
    drop_tail = (drop_cnt != '0);
    is_crlf   = (win[0].data == CHAR_CR) || (win[0].data == CHAR_LF);
    kept      = win[0].valid && !drop_tail && !skip && !is_crlf &&
                !((win[0].data == CHAR_LT) && hit);
    w_set     = win[0].fin ||
                (!drop_tail && !skip && (win[0].data == CHAR_LT) && wait_pre);
  end

  // Form the results of this step.
  always_comb begin
    cand_r   = '{data: win[0].data, valid: 1'b1, last: 1'b0};
    pend_r   = '{data: pend_data, valid: 1'b1, last: 1'b0};
    marker_r = '{data: 8'h00, valid: 1'b0, last: 1'b1};
    hres.count = 2'd0;
    hres.res0  = cand_r;
    hres.res1  = marker_r;
    if (win[0].valid && win[0].fin) begin
      if (kept) begin
        if (pend_valid) begin
          hres.count     = 2'd2;
          hres.res0      = pend_r;
          hres.res1      = cand_r;
          hres.res1.last = 1'b1;
        end else begin
          hres.count     = 2'd1;
          hres.res0      = cand_r;
          hres.res0.last = 1'b1;
        end
      end else if (pend_valid && pend_in_w) begin
        hres.count     = 2'd1;
        hres.res0      = pend_r;
        hres.res0.last = 1'b1;
      end else if (pend_valid) begin
        hres.count = 2'd2;
        hres.res0  = pend_r;
        hres.res1  = marker_r;
      end else begin
        hres.count = 2'd1;
        hres.res0  = marker_r;
      end
    end else if (kept && pend_valid) begin
      hres.count = 2'd1;
      hres.res0  = pend_r;
    end
  end

  // Advance the head state as the head byte leaves the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_cnt   <= '0;
      skip       <= 1'b0;
      w_reached  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (step && win[0].valid) begin
      if (win[0].fin) begin
        drop_cnt   <= '0;
        skip       <= 1'b0;
        w_reached  <= 1'b0;
        pend_valid <= 1'b0;
      end else begin
        w_reached <= w_reached | w_set;
        if (drop_tail) begin
          drop_cnt <= drop_cnt - 1'b1;
        end else if (skip) begin
          skip <= (win[0].data != CHAR_GT);
        end else if (!is_crlf && (win[0].data == CHAR_LT) && hit) begin
          drop_cnt <= hit_len;
          skip     <= hit_skip;
        end
        if (kept) begin
          pend_valid <= 1'b1;
          pend_in_w  <= w_reached | w_set;
          pend_data  <= win[0].data;
        end
      end
    end
  end

endmodule

@@ tb/sv/strip_checker.sv @@
module strip_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  input  logic       res_valid,
  input  logic       res_ready,
  input  logic [7:0] out_byte,
  input  logic       out_valid,
  input  logic       out_last,
  output int         fail_count,
  output int         results_due
);
  import hts_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } kept_t;

  typedef enum {TAG_MISS, TAG_HIT, TAG_MORE} tag_verdict_t;

  localparam int SHOW_LIMIT = 10;

  kept_t      kept_due [$];
  logic [7:0] window_q [$];
  bit         skip_open;
  int         shown;
  string      tag_pat [TAG_COUNT];
  bit         tag_opens_skip [TAG_COUNT];

  initial begin
    tag_pat = '{"<br />", "<br>", "<p>", "</p>", "<cite>", "</cite>",
                "<a ", "</a>", "<img ", "<blockquote>", "</blockquote>"};
    tag_opens_skip = '{0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0};
  end

  // Take one request into the window and work out the bytes it releases.
  task automatic strip_step(input logic [7:0] b, input logic fin);
    logic [7:0]   head;
    bit           hold;
    bit           removed;
    int           n;
    tag_verdict_t verdict;
    kept_t        r;
    hold = 0;
    n = 0;
    window_q.push_back(b);
    while (window_q.size() > 0 && !hold) begin
      head = window_q[0];
      // drop everything up to and including the closing bracket
      if (skip_open) begin
        void'(window_q.pop_front());
        if (head == CHAR_GT) skip_open = 0;
        continue;
      end
      if (head == CHAR_CR || head == CHAR_LF) begin
        void'(window_q.pop_front());
        continue;
      end
      removed = 0;
      // try tags in priority order; the first one not ruled out decides
      if (head == CHAR_LT) begin
        for (int t = 0; t < TAG_COUNT && !hold && !removed; t++) begin
          verdict = TAG_HIT;
          for (int i = 0; i < tag_pat[t].len(); i++) begin
            if (i >= window_q.size()) begin
              verdict = fin ? TAG_MISS : TAG_MORE;
              break;
            end
            if (window_q[i] != tag_pat[t][i]) begin
              verdict = TAG_MISS;
              break;
            end
          end
          if (verdict == TAG_MORE) begin
            hold = 1;
          end else if (verdict == TAG_HIT) begin
            repeat (tag_pat[t].len()) void'(window_q.pop_front());
            skip_open = tag_opens_skip[t];
            removed = 1;
          end
        end
      end
      if (!hold && !removed) begin
        r.data  = head;
        r.valid = 1'b1;
        r.last  = 1'b0;
        kept_due.push_back(r);
        n++;
        void'(window_q.pop_front());
      end
    end
    // close the string: flush, mark the last result or emit an empty marker
    if (fin) begin
      skip_open = 0;
      window_q.delete();
      if (n == 0) begin
        r.data  = 8'h00;
        r.valid = 1'b0;
        r.last  = 1'b1;
      end else begin
        r = kept_due.pop_back();
        r.last = 1'b1;
      end
      kept_due.push_back(r);
    end
  endtask

  // Predict on accepted requests, compare accepted results in order.
  always @(posedge clk) begin
    kept_t want;
    if (rst) begin
      window_q.delete();
      kept_due.delete();
      skip_open  = 0;
      shown      = 0;
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) strip_step(in_byte, is_final);
      if (res_valid && res_ready) begin
        if (kept_due.size() == 0) begin
          fail_count++;
          if (shown < SHOW_LIMIT)
            $display("result byte %02h valid %0b last %0b arrived with none due",
                     out_byte, out_valid, out_last);
          shown++;
        end else begin
          want = kept_due.pop_front();
          if (want.data !== out_byte || want.valid !== out_valid ||
              want.last !== out_last) begin
            fail_count++;
            if (shown < SHOW_LIMIT)
              $display({"mismatch: expected byte %02h valid %0b last %0b, ",
                        "got byte %02h valid %0b last %0b"},
                       want.data, want.valid, want.last, out_byte, out_valid, out_last);
            shown++;
          end
        end
      end
    end
    results_due = kept_due.size();
  end

endmodule

@@ tb/sv/tb_html_tag_stripper.sv @@
module tb_html_tag_stripper;
  import hts_pkg::*;

  localparam int ITEM_TARGET   = 280;
  localparam int CALM_ITEMS    = 40;
  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 20;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       is_final  = 1'b0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  int         fail_count;
  int         results_due;
  bit         quiet_tail = 0;
  int         sent       = 0;
  int         ready_hold = 0;
  int         next_tag   = 0;
  logic [7:0] text_q [$];
  string      tag_text [TAG_COUNT];

  html_tag_stripper uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .is_final  (is_final),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

  strip_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .is_final    (is_final),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .out_byte    (out_byte),
    .out_valid   (out_valid),
    .out_last    (out_last),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side in random bursts; stay ready in the calm tail.
  always @(posedge clk) begin
    if (rst || quiet_tail) begin
      res_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (res_ready && $urandom_range(0, 2) == 0) begin
      res_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 17);
    end else begin
      res_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 30);
    end
  end

  // End the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (res_valid && res_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("tb_html_tag_stripper failed");
    $finish;
  end

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Present one request, with an occasional idle burst ahead of it.
  task automatic send_request(input logic [7:0] b, input logic fin);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    is_final <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_request(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Hold the sender until every predicted byte has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic append_plain(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) text_q.push_back(8'($urandom_range(0, 255)));
      else text_q.push_back(8'($urandom_range(32, 126)));
    end
  endtask

  task automatic append_prefix();
    int t;
    int plen;
    t = $urandom_range(0, TAG_COUNT - 1);
    plen = $urandom_range(1, tag_text[t].len() - 1);
    for (int i = 0; i < plen; i++) text_q.push_back(tag_text[t][i]);
  endtask

  // Build one string: mostly whole tags and text, some broken tags and noise.
  task automatic compose_text();
    int         segs;
    int         t;
    int         fill;
    logic [7:0] c;
    segs = $urandom_range(1, 6);
    for (int s = 0; s < segs; s++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          t = next_tag;
          next_tag = (next_tag + 1) % TAG_COUNT;
          append_text(tag_text[t]);
          if (TAG_SKIP[t]) begin
            fill = $urandom_range(0, 4);
            for (int i = 0; i < fill; i++) begin
              c = 8'($urandom_range(32, 126));
              text_q.push_back(c == CHAR_GT ? 8'h78 : c);
            end
            if ($urandom_range(0, 4) != 0) text_q.push_back(CHAR_GT);
          end
        end
        3: begin
          append_prefix();
          text_q.push_back(8'($urandom_range(0, 255)));
        end
        4: begin
          case ($urandom_range(0, 2))
            0: text_q.push_back(CHAR_CR);
            1: text_q.push_back(CHAR_LF);
            default: append_text("\r\n");
          endcase
        end
        5: begin
          if ($urandom_range(0, 1) == 0) begin
            text_q.push_back(CHAR_LT);
            text_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            text_q.push_back(CHAR_GT);
          end
        end
        default: append_plain($urandom_range(1, 4));
      endcase
    end
    // leave a tag unfinished at the end now and then
    if ($urandom_range(0, 5) == 0) append_prefix();
  endtask

  initial begin
    tag_text = '{"<br />", "<br>", "<p>", "</p>", "<cite>", "</cite>",
                 "<a ", "</a>", "<img ", "<blockquote>", "</blockquote>"};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty end, byte extremes, skips, unfinished tags
    append_text("\n");
    send_text();
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    append_text("<p>z");
    send_text();
    append_text("<a q>k");
    send_text();
    append_text("<img x");
    send_text();
    append_text("<bl");
    send_text();
    append_text("<");
    send_text();
    drain_results();

    // random strings, with an occasional full drain between them
    while (sent < ITEM_TARGET) begin
      if (sent >= ITEM_TARGET - CALM_ITEMS) quiet_tail = 1;
      compose_text();
      send_text();
      if (!quiet_tail && $urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("tb_html_tag_stripper passed");
    end else begin
      $display("tb_html_tag_stripper failed");
    end
    $finish;
  end

endmodule
